// File: design/pswt_pkg.sv
`default_nettype none

package pswt_pkg;

  // Field widths of one job and of one result.
  localparam int unsigned BURST_W = 16;
  localparam int unsigned PRIO_W = 8;
  localparam int unsigned ORDER_W = 5;
  localparam int unsigned WAIT_W = 21;
  localparam int unsigned AVG_W = 29;
  localparam int unsigned FRAC_W = 8;

  // Default size of the job store.
  localparam int unsigned MAX_JOBS_DEF = 32;

  // Default divider widths for the default store size.
  localparam int unsigned DIVD_W_DEF = BURST_W + 2 * $clog2(MAX_JOBS_DEF) + FRAC_W;
  localparam int unsigned DIVS_W_DEF = $clog2(MAX_JOBS_DEF + 1);

  // One stored job.
  typedef struct packed {
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
  } job_t;

  // Datapath operations, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RD_A,
    OP_LD_A,
    OP_SCAN,
    OP_WR_A,
    OP_WR_B,
    OP_EM_RD,
    OP_EM_OUT,
    OP_DIV_GO,
    OP_FINISH
  } dp_op_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_RD_A,
    ST_LD_A,
    ST_SCAN,
    ST_WR_A,
    ST_WR_B,
    ST_EM_RD,
    ST_EM_OUT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FINISH
  } state_e;

  // Command from the controller to the datapath.
  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic closing;
    logic one_job;
    logic scan_done;
    logic sort_done;
    logic em_last;
    logic div_done;
  } stat_t;

endpackage

`default_nettype wire

// File: design/pswt_divider.sv
`default_nettype none

module pswt_divider #(
  parameter int unsigned DIVD_W = pswt_pkg::DIVD_W_DEF,
  parameter int unsigned DIVS_W = pswt_pkg::DIVS_W_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [DIVS_W-1:0]      divisor_i,
  input  wire logic [1:0][DIVD_W-1:0] dividend_i,
  output logic      [1:0][DIVD_W-1:0] quotient_o,
  output logic                        done_o
);
  import pswt_pkg::*;

  localparam int unsigned STEP_W = $clog2(DIVD_W + 1);

  logic [STEP_W-1:0]        step_q, step_d;
  logic [DIVS_W-1:0]        divisor_q;
  logic [1:0][DIVS_W-1:0]   rem_q, rem_d;
  logic [1:0][DIVD_W-1:0]   quo_q, quo_d;
  logic [1:0][DIVS_W:0]     trial;
  logic [1:0][DIVS_W:0]     diff;

  // One restoring step per cycle in each of the two lanes, which share the divisor.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      trial[l] = {rem_q[l], quo_q[l][DIVD_W-1]};
      diff[l]  = trial[l] - {1'b0, divisor_q};
      if (trial[l] >= {1'b0, divisor_q}) begin
        rem_d[l] = diff[l][DIVS_W-1:0];
        quo_d[l] = {quo_q[l][DIVD_W-2:0], 1'b1};
      end else begin
        rem_d[l] = trial[l][DIVS_W-1:0];
        quo_d[l] = {quo_q[l][DIVD_W-2:0], 1'b0};
      end
    end
  end

  // Step counter: loaded on start, counts down to zero.
  always_comb begin
    step_d = step_q;
    if (start_i) begin
      step_d = STEP_W'(DIVD_W);
    end else if (step_q != '0) begin
      step_d = step_q - STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  // Remainder and quotient registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      divisor_q <= divisor_i;
      rem_q     <= '0;
      quo_q     <= dividend_i;
    end else if (step_q != '0) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = (step_q == '0);

endmodule

`default_nettype wire

// File: design/pswt_datapath.sv
`default_nettype none

module pswt_datapath #(
  parameter int unsigned MAX_JOBS = pswt_pkg::MAX_JOBS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire pswt_pkg::cmd_t               cmd_i,
  output pswt_pkg::stat_t                   stat_o,
  input  wire logic [pswt_pkg::BURST_W-1:0] burst_time_i,
  input  wire logic [pswt_pkg::PRIO_W-1:0]  job_priority_i,
  input  wire logic                         last_job_i,
  output logic                              result_valid_o,
  output logic      [pswt_pkg::ORDER_W-1:0] order_index_o,
  output logic      [pswt_pkg::BURST_W-1:0] burst_out_o,
  output logic      [pswt_pkg::PRIO_W-1:0]  priority_out_o,
  output logic      [pswt_pkg::WAIT_W-1:0]  waiting_time_o,
  output logic      [pswt_pkg::WAIT_W-1:0]  turnaround_time_o,
  output logic      [pswt_pkg::AVG_W-1:0]   avg_waiting_q8_o,
  output logic      [pswt_pkg::AVG_W-1:0]   avg_turnaround_q8_o,
  output logic                              last_result_o
);
  import pswt_pkg::*;

  localparam int unsigned IDX_W     = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_JOBS + 1);
  localparam int unsigned ELAPSED_W = BURST_W + $clog2(MAX_JOBS);
  localparam int unsigned SUM_W     = BURST_W + 2 * $clog2(MAX_JOBS);
  localparam int unsigned DIVD_W    = SUM_W + FRAC_W;

  // Job store.
  job_t job_mem [MAX_JOBS];

  logic                 we;
  logic [IDX_W-1:0]     waddr;
  job_t                 wdata;
  logic                 re;
  logic [CNT_W-1:0]     raddr_full;

  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     cnt_m1;
  logic [CNT_W-1:0]     a_q, a_d;
  logic [CNT_W-1:0]     b_q, b_d;
  logic [CNT_W-1:0]     k_q, k_d;
  job_t                 rd_q;
  logic [CNT_W-1:0]     rd_idx_q;
  job_t                 best_q, best_d;
  logic [CNT_W-1:0]     best_idx_q, best_idx_d;
  job_t                 cur_q, cur_d;
  logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;
  logic [ELAPSED_W-1:0] tat;
  logic [SUM_W-1:0]     wsum_q, wsum_d;
  logic [SUM_W-1:0]     tsum_q, tsum_d;

  logic                 valid_q, valid_d;
  logic [ORDER_W-1:0]   order_q, order_d;
  job_t                 out_job_q, out_job_d;
  logic [WAIT_W-1:0]    wait_q, wait_d;
  logic [WAIT_W-1:0]    tat_q, tat_d;
  logic [AVG_W-1:0]     avg_w_q, avg_w_d;
  logic [AVG_W-1:0]     avg_t_q, avg_t_d;
  logic                 last_q, last_d;

  logic                   div_start;
  logic [1:0][DIVD_W-1:0] dividend;
  logic [1:0][DIVD_W-1:0] quotient;
  logic                   div_done;

  assign cnt_m1 = count_q - CNT_W'(1);
  assign tat    = elapsed_q + ELAPSED_W'(rd_q.burst);

  // Status towards the controller.
  always_comb begin
    stat_o.closing   = last_job_i || (count_q == CNT_W'(MAX_JOBS - 1));
    stat_o.one_job   = (count_q == CNT_W'(1));
    stat_o.scan_done = (rd_idx_q == cnt_m1);
    stat_o.sort_done = ((a_q + CNT_W'(1)) == cnt_m1);
    stat_o.em_last   = (k_q == cnt_m1);
    stat_o.div_done  = div_done;
  end

  // Next-state logic for every operation.
  always_comb begin
    count_d    = count_q;
    a_d        = a_q;
    b_d        = b_q;
    k_d        = k_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    cur_d      = cur_q;
    elapsed_d  = elapsed_q;
    wsum_d     = wsum_q;
    tsum_d     = tsum_q;
    valid_d    = 1'b0;
    order_d    = order_q;
    out_job_d  = out_job_q;
    wait_d     = wait_q;
    tat_d      = tat_q;
    avg_w_d    = avg_w_q;
    avg_t_d    = avg_t_q;
    last_d     = last_q;
    we         = 1'b0;
    waddr      = a_q[IDX_W-1:0];
    wdata      = best_q;
    re         = 1'b0;
    raddr_full = a_q;
    div_start  = 1'b0;
    case (cmd_i.op)
      OP_LOAD: begin
        we          = 1'b1;
        waddr       = count_q[IDX_W-1:0];
        wdata.burst = burst_time_i;
        wdata.prio  = job_priority_i;
        count_d     = count_q + CNT_W'(1);
        a_d         = '0;
        k_d         = '0;
        elapsed_d   = '0;
        wsum_d      = '0;
        tsum_d      = '0;
      end
      OP_RD_A: begin
        re         = 1'b1;
        raddr_full = a_q;
      end
      OP_LD_A: begin
        cur_d      = rd_q;
        best_d     = rd_q;
        best_idx_d = rd_idx_q;
        re         = 1'b1;
        raddr_full = a_q + CNT_W'(1);
        b_d        = a_q + CNT_W'(2);
      end
      OP_SCAN: begin
        // Strict less-than keeps the first smallest priority.
        if (rd_q.prio < best_q.prio) begin
          best_d     = rd_q;
          best_idx_d = rd_idx_q;
        end
        if (!stat_o.scan_done) begin
          re         = 1'b1;
          raddr_full = b_q;
          b_d        = b_q + CNT_W'(1);
        end
      end
      OP_WR_A: begin
        we    = 1'b1;
        waddr = a_q[IDX_W-1:0];
        wdata = best_q;
      end
      OP_WR_B: begin
        we    = 1'b1;
        waddr = best_idx_q[IDX_W-1:0];
        wdata = cur_q;
        a_d   = a_q + CNT_W'(1);
      end
      OP_EM_RD: begin
        re         = 1'b1;
        raddr_full = k_q;
      end
      OP_EM_OUT: begin
        order_d   = ORDER_W'(k_q);
        out_job_d = rd_q;
        wait_d    = WAIT_W'(elapsed_q);
        tat_d     = WAIT_W'(tat);
        avg_w_d   = '0;
        avg_t_d   = '0;
        last_d    = 1'b0;
        valid_d   = !stat_o.em_last;
        wsum_d    = wsum_q + SUM_W'(elapsed_q);
        tsum_d    = tsum_q + SUM_W'(tat);
        elapsed_d = tat;
        k_d       = k_q + CNT_W'(1);
      end
      OP_DIV_GO: begin
        div_start = 1'b1;
      end
      OP_FINISH: begin
        avg_w_d = AVG_W'(quotient[0]);
        avg_t_d = AVG_W'(quotient[1]);
        last_d  = 1'b1;
        valid_d = 1'b1;
        count_d = '0;
      end
      default: ;
    endcase
  end

  // Store write and registered read.
  always_ff @(posedge clk_i) begin
    if (we) begin
      job_mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q     <= job_mem[raddr_full[IDX_W-1:0]];
      rd_idx_q <= raddr_full;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    k_q        <= k_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    cur_q      <= cur_d;
    elapsed_q  <= elapsed_d;
    wsum_q     <= wsum_d;
    tsum_q     <= tsum_d;
    order_q    <= order_d;
    out_job_q  <= out_job_d;
    wait_q     <= wait_d;
    tat_q      <= tat_d;
    avg_w_q    <= avg_w_d;
    avg_t_q    <= avg_t_d;
    last_q     <= last_d;
  end

  // Averages: both sums scaled by the fraction bits, divided by the job count.
  assign dividend[0] = {wsum_q, {FRAC_W{1'b0}}};
  assign dividend[1] = {tsum_q, {FRAC_W{1'b0}}};

  pswt_divider #(
    .DIVD_W(DIVD_W),
    .DIVS_W(CNT_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .divisor_i  (count_q),
    .dividend_i (dividend),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  assign result_valid_o      = valid_q;
  assign order_index_o       = order_q;
  assign burst_out_o         = out_job_q.burst;
  assign priority_out_o      = out_job_q.prio;
  assign waiting_time_o      = wait_q;
  assign turnaround_time_o   = tat_q;
  assign avg_waiting_q8_o    = avg_w_q;
  assign avg_turnaround_q8_o = avg_t_q;
  assign last_result_o       = last_q;

endmodule

`default_nettype wire

// File: design/pswt_controller.sv
`default_nettype none

module pswt_controller (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire pswt_pkg::stat_t stat_i,
  output pswt_pkg::cmd_t       cmd_o,
  output logic                 busy_o
);
  import pswt_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath command.
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.op = OP_LOAD;
          if (stat_i.closing) begin
            state_d = ST_START;
          end
        end
      end
      ST_START: begin
        // A single job needs no ordering.
        state_d = stat_i.one_job ? ST_EM_RD : ST_RD_A;
      end
      ST_RD_A: begin
        cmd_o.op = OP_RD_A;
        state_d  = ST_LD_A;
      end
      ST_LD_A: begin
        cmd_o.op = OP_LD_A;
        state_d  = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.op = OP_SCAN;
        if (stat_i.scan_done) begin
          state_d = ST_WR_A;
        end
      end
      ST_WR_A: begin
        cmd_o.op = OP_WR_A;
        state_d  = ST_WR_B;
      end
      ST_WR_B: begin
        cmd_o.op = OP_WR_B;
        state_d  = stat_i.sort_done ? ST_EM_RD : ST_RD_A;
      end
      ST_EM_RD: begin
        cmd_o.op = OP_EM_RD;
        state_d  = ST_EM_OUT;
      end
      ST_EM_OUT: begin
        cmd_o.op = OP_EM_OUT;
        state_d  = stat_i.em_last ? ST_DIV_GO : ST_EM_RD;
      end
      ST_DIV_GO: begin
        cmd_o.op = OP_DIV_GO;
        state_d  = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (stat_i.div_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.op = OP_FINISH;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// File: design/priority_schedule_wait_times_unit.sv
`default_nettype none

// Each job transaction is taken while idle; the set closes on last_job or when the store is full.
// Ordering a set of n jobs is a selection sort, at most one store read per cycle.
// Results then follow, each after its own store read; the last one waits for the averages
// divider, one quotient bit per cycle. Results cannot be stalled.
// Reset clears the controller, the divider step counter, the job count and the result strobe;
// the job store is left undefined and gets no clearing pass.
module priority_schedule_wait_times_unit #(
  parameter int unsigned MAX_JOBS = pswt_pkg::MAX_JOBS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [pswt_pkg::BURST_W-1:0] burst_time_i,
  input  wire logic [pswt_pkg::PRIO_W-1:0]  job_priority_i,
  input  wire logic                         last_job_i,
  output logic                              result_valid_o,
  output logic      [pswt_pkg::ORDER_W-1:0] order_index_o,
  output logic      [pswt_pkg::BURST_W-1:0] burst_out_o,
  output logic      [pswt_pkg::PRIO_W-1:0]  priority_out_o,
  output logic      [pswt_pkg::WAIT_W-1:0]  waiting_time_o,
  output logic      [pswt_pkg::WAIT_W-1:0]  turnaround_time_o,
  output logic      [pswt_pkg::AVG_W-1:0]   avg_waiting_q8_o,
  output logic      [pswt_pkg::AVG_W-1:0]   avg_turnaround_q8_o,
  output logic                              last_result_o
);
  import pswt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  pswt_controller u_controller (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // Store, sort registers, accumulators and result registers.
  pswt_datapath #(
    .MAX_JOBS(MAX_JOBS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .burst_time_i        (burst_time_i),
    .job_priority_i      (job_priority_i),
    .last_job_i          (last_job_i),
    .result_valid_o      (result_valid_o),
    .order_index_o       (order_index_o),
    .burst_out_o         (burst_out_o),
    .priority_out_o      (priority_out_o),
    .waiting_time_o      (waiting_time_o),
    .turnaround_time_o   (turnaround_time_o),
    .avg_waiting_q8_o    (avg_waiting_q8_o),
    .avg_turnaround_q8_o (avg_turnaround_q8_o),
    .last_result_o       (last_result_o)
  );

`ifndef NO_ASSERTIONS
  // Results are never shown in two consecutive cycles.
  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("two results in consecutive cycles");

  // Averages appear only on the final result of a set.
  a_avg_last_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_result_o) |->
      (avg_waiting_q8_o == '0 && avg_turnaround_q8_o == '0))
    else $error("averages on a result that is not the last");

  // Turnaround is the waiting time plus the job's own burst.
  a_tat_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      (turnaround_time_o == WAIT_W'(waiting_time_o + WAIT_W'(burst_out_o))))
    else $error("turnaround does not match waiting time plus burst");

  // The final result leaves the block ready for a new set.
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_result_o) |-> !busy)
    else $error("block still busy on the final result");
`endif

endmodule

`default_nettype wire

// File: dv/tb_priority_schedule_wait_times_unit.sv
`default_nettype none

module tb_priority_schedule_wait_times_unit;
  import pswt_pkg::*;

  localparam int unsigned MAX_JOBS = MAX_JOBS_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_ITEMS = 30;

  // One expected result transaction, at the widths of the result ports.
  typedef struct {
    logic [ORDER_W-1:0] order;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic [WAIT_W-1:0]  waiting;
    logic [WAIT_W-1:0]  turnaround;
    logic [AVG_W-1:0]   avg_waiting;
    logic [AVG_W-1:0]   avg_turnaround;
    logic               final_job;
  } sched_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [BURST_W-1:0] burst_time_i;
  logic [PRIO_W-1:0]  job_priority_i;
  logic               last_job_i;
  logic               result_valid_o;
  logic [ORDER_W-1:0] order_index_o;
  logic [BURST_W-1:0] burst_out_o;
  logic [PRIO_W-1:0]  priority_out_o;
  logic [WAIT_W-1:0]  waiting_time_o;
  logic [WAIT_W-1:0]  turnaround_time_o;
  logic [AVG_W-1:0]   avg_waiting_q8_o;
  logic [AVG_W-1:0]   avg_turnaround_q8_o;
  logic               last_result_o;

  // Jobs held for the open set, as the block should hold them.
  logic [BURST_W-1:0] held_burst [MAX_JOBS];
  logic [PRIO_W-1:0]  held_prio [MAX_JOBS];
  int unsigned        held_count;

  sched_result_t      served_order_q [$];
  sched_result_t      seen_want;
  int unsigned        error_count;
  int unsigned        cycle_count;
  int unsigned        jobs_sent;
  bit                 gaps_on;

  priority_schedule_wait_times_unit #(
    .MAX_JOBS(MAX_JOBS)
  ) i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .burst_time_i       (burst_time_i),
    .job_priority_i     (job_priority_i),
    .last_job_i         (last_job_i),
    .result_valid_o     (result_valid_o),
    .order_index_o      (order_index_o),
    .burst_out_o        (burst_out_o),
    .priority_out_o     (priority_out_o),
    .waiting_time_o     (waiting_time_o),
    .turnaround_time_o  (turnaround_time_o),
    .avg_waiting_q8_o   (avg_waiting_q8_o),
    .avg_turnaround_q8_o(avg_turnaround_q8_o),
    .last_result_o      (last_result_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Count cycles and give up if the run hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_priority_schedule_wait_times_unit: done, errors");
      $finish;
    end
  end

  // Print one line for a mismatch and count it; printing stops after a hundred.
  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    error_count++;
    if (error_count <= 100) begin
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    end
  endtask

  // Store an accepted job and, when the set closes, work out its served order.
  task automatic accept_job(input logic [BURST_W-1:0] b, input logic [PRIO_W-1:0] p,
                            input logic is_last, output bit closing);
    logic [BURST_W-1:0] bs [MAX_JOBS];
    logic [PRIO_W-1:0]  ps [MAX_JOBS];
    logic [BURST_W-1:0] tb;
    logic [PRIO_W-1:0]  tp;
    int unsigned        n;
    int unsigned        best;
    longint unsigned    elapsed;
    longint unsigned    wsum;
    longint unsigned    tsum;
    sched_result_t      res;
    if (held_count >= MAX_JOBS) held_count = 0;
    held_burst[held_count] = b;
    held_prio[held_count] = p;
    held_count++;
    jobs_sent++;
    closing = is_last || (held_count >= MAX_JOBS);
    if (!closing) return;

    // Selection sort with a strict less-than and an unconditional swap.
    n = held_count;
    for (int unsigned a = 0; a < n; a++) begin
      bs[a] = held_burst[a];
      ps[a] = held_prio[a];
    end
    for (int unsigned a = 0; a < n; a++) begin
      best = a;
      for (int unsigned j = a + 1; j < n; j++) begin
        if (ps[j] < ps[best]) best = j;
      end
      tp = ps[a];
      tb = bs[a];
      ps[a] = ps[best];
      ps[best] = tp;
      bs[a] = bs[best];
      bs[best] = tb;
    end

    // The sums are needed on the last result, so gather them first.
    elapsed = 0;
    wsum = 0;
    tsum = 0;
    for (int unsigned k = 0; k < n; k++) begin
      wsum += elapsed;
      elapsed += bs[k];
      tsum += elapsed;
    end

    elapsed = 0;
    for (int unsigned k = 0; k < n; k++) begin
      res.order = k[ORDER_W-1:0];
      res.burst = bs[k];
      res.prio = ps[k];
      res.waiting = elapsed[WAIT_W-1:0];
      elapsed += bs[k];
      res.turnaround = elapsed[WAIT_W-1:0];
      res.final_job = (k == n - 1);
      res.avg_waiting = res.final_job ? AVG_W'((wsum << FRAC_W) / n) : '0;
      res.avg_turnaround = res.final_job ? AVG_W'((tsum << FRAC_W) / n) : '0;
      served_order_q.push_back(res);
    end
    held_count = 0;
  endtask

  // Send one job transaction; start stays high into the next call unless the set closed.
  task automatic send_job(input logic [BURST_W-1:0] b, input logic [PRIO_W-1:0] p,
                          input logic is_last);
    bit closing;
    @(negedge clk_i);
    while (gaps_on && $urandom_range(99) < 20) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    burst_time_i <= b;
    job_priority_i <= p;
    last_job_i <= is_last;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    accept_job(b, p, is_last, closing);
    if (closing) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  // Compare each result transaction with the oldest expected one.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) begin
      if (served_order_q.size() == 0) begin
        report_mismatch("unexpected result, order_index", order_index_o, 0);
      end else begin
        seen_want = served_order_q.pop_front();
        if (order_index_o !== seen_want.order)
          report_mismatch("order_index", order_index_o, seen_want.order);
        if (burst_out_o !== seen_want.burst)
          report_mismatch("burst_out", burst_out_o, seen_want.burst);
        if (priority_out_o !== seen_want.prio)
          report_mismatch("priority_out", priority_out_o, seen_want.prio);
        if (waiting_time_o !== seen_want.waiting)
          report_mismatch("waiting_time", waiting_time_o, seen_want.waiting);
        if (turnaround_time_o !== seen_want.turnaround)
          report_mismatch("turnaround_time", turnaround_time_o, seen_want.turnaround);
        if (avg_waiting_q8_o !== seen_want.avg_waiting)
          report_mismatch("avg_waiting_q8", avg_waiting_q8_o, seen_want.avg_waiting);
        if (avg_turnaround_q8_o !== seen_want.avg_turnaround)
          report_mismatch("avg_turnaround_q8", avg_turnaround_q8_o, seen_want.avg_turnaround);
        if (last_result_o !== seen_want.final_job)
          report_mismatch("last_result", last_result_o, seen_want.final_job);
      end
    end
  end

  // Burst values lean towards the extremes now and then.
  function automatic logic [BURST_W-1:0] pick_burst();
    int unsigned r;
    r = $urandom_range(7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return BURST_W'($urandom());
  endfunction

  // Sets of one job, at both extremes of the fields.
  task automatic test_single_job();
    send_job('0, '0, 1'b1);
    send_job('1, '1, 1'b1);
  endtask

  // A small set mixing extreme bursts and priorities.
  task automatic test_field_extremes();
    send_job('1, '1, 1'b0);
    send_job('0, '0, 1'b0);
    send_job('1, '0, 1'b0);
    send_job(16'd1, 8'd128, 1'b1);
  endtask

  // Equal priorities, where the swap procedure decides the served order.
  task automatic test_priority_ties();
    for (int unsigned k = 0; k < 5; k++) send_job(BURST_W'(100 + k), 8'd7, k == 4);
    send_job(16'd10, 8'd3, 1'b0);
    send_job(16'd20, 8'd1, 1'b0);
    send_job(16'd30, 8'd3, 1'b0);
    send_job(16'd40, 8'd1, 1'b0);
    send_job(16'd50, 8'd3, 1'b1);
  endtask

  // A full store closes the set by itself; then a set closed on its last job.
  task automatic test_full_store();
    for (int unsigned k = 0; k < MAX_JOBS; k++) send_job('1, PRIO_W'($urandom()), 1'b0);
    for (int unsigned k = 0; k < MAX_JOBS; k++) begin
      send_job(pick_burst(), PRIO_W'($urandom()), k == MAX_JOBS - 1);
    end
    send_job(16'd5, 8'd9, 1'b0);
    send_job(16'd6, 8'd2, 1'b1);
  endtask

  // Random sets, mostly small, a few full ones and some with narrow priorities.
  task automatic test_random_sets(input int unsigned item_goal);
    int unsigned goal;
    int unsigned size;
    int unsigned r;
    bit          narrow;
    bit          auto_close;
    goal = jobs_sent + item_goal;
    while (jobs_sent < goal) begin
      r = $urandom_range(99);
      if (r < 8) size = MAX_JOBS;
      else if (r < 20) size = $urandom_range(MAX_JOBS - 1, 9);
      else size = $urandom_range(8, 1);
      narrow = ($urandom_range(3) == 0);
      auto_close = (size == MAX_JOBS) && $urandom_range(1);
      for (int unsigned k = 0; k < size; k++) begin
        send_job(pick_burst(),
                 narrow ? PRIO_W'($urandom_range(3)) : PRIO_W'($urandom()),
                 (k == size - 1) && !auto_close);
      end
    end
  endtask

  // Reset, the tests in turn, then drain and give the verdict.
  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    burst_time_i = '0;
    job_priority_i = '0;
    last_job_i = 1'b0;
    held_count = 0;
    error_count = 0;
    cycle_count = 0;
    jobs_sent = 0;
    gaps_on = 1'b1;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_single_job();
    test_field_extremes();
    test_priority_ties();
    test_full_store();
    test_random_sets(RANDOM_ITEMS / 3);
    gaps_on = 1'b0;
    test_random_sets(RANDOM_ITEMS / 2);
    gaps_on = 1'b1;
    test_random_sets(RANDOM_ITEMS / 6);

    while (served_order_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_priority_schedule_wait_times_unit: done, clean");
    end else begin
      $display("tb_priority_schedule_wait_times_unit: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: priority_schedule_wait_times_unit.f
design/pswt_pkg.sv
design/pswt_divider.sv
design/pswt_datapath.sv
design/pswt_controller.sv
design/priority_schedule_wait_times_unit.sv
dv/tb_priority_schedule_wait_times_unit.sv
